@@ sv/voxel_grid_centroid_downsample_unit_defines.svh @@
// assertion helpers for the bound checker in sv/vgc_checker.sv
`ifndef VOXEL_GRID_CENTROID_DOWNSAMPLE_UNIT_DEFINES_SVH
`define VOXEL_GRID_CENTROID_DOWNSAMPLE_UNIT_DEFINES_SVH

// same-cycle implication
`define VGC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/vgc_pkg.sv @@
package vgc_pkg;

   localparam int DEF_CAPACITY    = 1024;
   localparam int DEF_PROBE_LIMIT = 16;
   localparam int SLOT_W          = 16;

   localparam logic [31:0] VOXEL_RESET = 32'd65536;
   localparam logic [31:0] MIN_VOXEL   = 32'd655;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

   localparam logic [31:0] HASH_X = 32'd73856093;
   localparam logic [31:0] HASH_Y = 32'd19349663;
   localparam logic [31:0] HASH_Z = 32'd83492791;

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_PASS  = 2'd1;
   localparam logic [1:0] OP_DRAIN = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_SAT   = 2'd3;

   typedef struct packed {
      logic [1:0]        op;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       key_x;
      logic [31:0]       key_y;
      logic [31:0]       key_z;
      logic [31:0]       x;
      logic [31:0]       y;
      logic [31:0]       z;
      logic [15:0]       inten;
   } op_type;

   typedef struct packed {
      logic [31:0] key_x;
      logic [31:0] key_y;
      logic [31:0] key_z;
      logic [47:0] sum_x;
      logic [47:0] sum_y;
      logic [47:0] sum_z;
      logic [31:0] sum_i;
      logic [15:0] count;
   } entry_type;

endpackage

@@ sv/voxel_grid_centroid_downsample_unit.sv @@
// channel | direction | transaction contents
// req     | in        | tdata: x, y, z, intensity; tuser: kind (add / drain)
// rsp     | out       | tdata: x, y, z, intensity; tuser: point_valid, status; tlast
// csr     | in        | data: voxel size, unsigned q16.16
//
// add: the front runs a 32-step coordinate division, the hash and the home
//   slot from the low hash bits, then the back table reads and checks each probe
// drain: a read and a check per slot scanned, a 48-step averaging division, a read
//   and a check per slot scanned ahead; pass-through and drain ops skip the division
// reset and the final drained voxel start a clearing pass over all CAPACITY slots
//   of the occupancy memory; req_tready stays low meanwhile
// a finished result waits in the output register while the next op proceeds
module voxel_grid_centroid_downsample_unit #(
   parameter int CAPACITY    = vgc_pkg::DEF_CAPACITY,
   parameter int PROBE_LIMIT = vgc_pkg::DEF_PROBE_LIMIT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // x_in, y_in, z_in, intensity_in
   input  logic         req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // x_out, y_out, z_out, intensity_out
   output logic [2:0]   rsp_tuser,   // point_valid, status
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);
   import vgc_pkg::*;

   op_type f_op, b_op;
   logic   f_valid, f_ready, b_valid, b_ready, clearing;

   // voxel size register lives in the front; writes never stall
   assign csr_ready = 1'b1;

   // front: classify, compute cell keys and home slot
   vgc_front #(.CAPACITY(CAPACITY)) u_front (
      .clock, .reset, .clearing,
      .item_valid(req_tvalid), .item_ready(req_tready), .item_kind(req_tuser),
      .item_x(req_tdata[31:0]), .item_y(req_tdata[63:32]), .item_z(req_tdata[95:64]),
      .item_inten(req_tdata[111:96]),
      .cfg_valid(csr_valid && csr_ready), .cfg_data(csr_data),
      .push_valid(f_valid), .push_ready(f_ready), .push_data(f_op));

   // short op queue decouples the two halves
   vgc_queue u_queue (
      .clock, .reset,
      .push_valid(f_valid), .push_ready(f_ready), .push_data(f_op),
      .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_op));

   // back: hash table probing, accumulation, drain and averaging
   vgc_back #(.CAPACITY(CAPACITY), .PROBE_LIMIT(PROBE_LIMIT)) u_back (
      .clock, .reset,
      .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_op), .clearing,
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp_data(rsp_tdata),
      .rsp_user(rsp_tuser), .rsp_last(rsp_tlast));
endmodule

@@ sv/vgc_ram.sv @@
module vgc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/vgc_divider.sv @@
module vgc_divider #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);
   localparam int CW = $clog2(WIDTH);

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [WIDTH:0]   shifted, diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      diff    = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(WIDTH-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

@@ sv/vgc_queue.sv @@
module vgc_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  vgc_pkg::op_type push_data,
   output logic            pop_valid,
   input  logic            pop_ready,
   output vgc_pkg::op_type pop_data
);
   import vgc_pkg::*;

   op_type     entry_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

@@ sv/vgc_front.sv @@
module vgc_front #(
   parameter int CAPACITY = vgc_pkg::DEF_CAPACITY
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            clearing,
   input  logic            item_valid,
   output logic            item_ready,
   input  logic            item_kind,
   input  logic [31:0]     item_x,
   input  logic [31:0]     item_y,
   input  logic [31:0]     item_z,
   input  logic [15:0]     item_inten,
   input  logic            cfg_valid,
   input  logic [31:0]     cfg_data,
   output logic            push_valid,
   input  logic            push_ready,
   output vgc_pkg::op_type push_data
);
   import vgc_pkg::*;

   localparam logic [2:0] F_IDLE  = 3'd0;
   localparam logic [2:0] F_DIV   = 3'd1;
   localparam logic [2:0] F_HASH  = 3'd2;
   localparam logic [2:0] F_SLOT  = 3'd3;
   localparam logic [2:0] F_PUSH  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] voxel_ff;
   op_type      op_ff, op_in;
   logic [31:0] kx_ff, ky_ff, kz_ff, kx_in, ky_in, kz_in;
   logic [31:0] hash_ff, hash_in;
   logic        accept, div_start;
   logic [31:0] ax, ay, az, qx, qy, qz, rx, ry, rz;
   logic        dx_done, dy_done, dz_done;

   assign item_ready = (state_ff == F_IDLE) && !clearing;
   assign accept     = item_valid && item_ready;
   assign div_start  = accept && (item_kind == KIND_ADD) && (voxel_ff >= MIN_VOXEL);

   assign ax = item_x[31] ? (~item_x + 32'd1) : item_x;
   assign ay = item_y[31] ? (~item_y + 32'd1) : item_y;
   assign az = item_z[31] ? (~item_z + 32'd1) : item_z;

   vgc_divider #(.WIDTH(32)) u_div_x (
      .clock, .reset, .start(div_start), .dividend(ax), .divisor(voxel_ff),
      .done(dx_done), .quotient(qx), .remainder(rx));
   vgc_divider #(.WIDTH(32)) u_div_y (
      .clock, .reset, .start(div_start), .dividend(ay), .divisor(voxel_ff),
      .done(dy_done), .quotient(qy), .remainder(ry));
   vgc_divider #(.WIDTH(32)) u_div_z (
      .clock, .reset, .start(div_start), .dividend(az), .divisor(voxel_ff),
      .done(dz_done), .quotient(qz), .remainder(rz));

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      kx_in    = kx_ff;
      ky_in    = ky_ff;
      kz_in    = kz_ff;
      hash_in  = hash_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               op_in.x     = item_x;
               op_in.y     = item_y;
               op_in.z     = item_z;
               op_in.inten = item_inten;
               op_in.slot  = '0;
               op_in.key_x = '0;
               op_in.key_y = '0;
               op_in.key_z = '0;
               if (item_kind == KIND_DRAIN) begin
                  op_in.op = OP_DRAIN;
                  state_in = F_PUSH;
               end else if (voxel_ff < MIN_VOXEL) begin
                  op_in.op = OP_PASS;
                  state_in = F_PUSH;
               end else begin
                  op_in.op = OP_ADD;
                  state_in = F_DIV;
               end
            end
         end
         F_DIV: begin
            if (dx_done && dy_done && dz_done) begin
               // negative side: -(q) - 1 is the complement of q
               kx_in    = op_ff.x[31] ? ~qx : qx;
               ky_in    = op_ff.y[31] ? ~qy : qy;
               kz_in    = op_ff.z[31] ? ~qz : qz;
               state_in = F_HASH;
            end
         end
         F_HASH: begin
            hash_in     = (kx_ff * HASH_X) ^ (ky_ff * HASH_Y) ^ (kz_ff * HASH_Z);
            op_in.key_x = kx_ff;
            op_in.key_y = ky_ff;
            op_in.key_z = kz_ff;
            state_in    = F_SLOT;
         end
         F_SLOT: begin
            // power-of-two table: home slot is the low hash bits
            op_in.slot = hash_ff[SLOT_W-1:0] & SLOT_W'(CAPACITY - 1);
            state_in   = F_PUSH;
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         voxel_ff <= VOXEL_RESET;
      end else begin
         state_ff <= state_in;
         if (cfg_valid) begin
            voxel_ff <= cfg_data;
         end
      end
      op_ff   <= op_in;
      kx_ff   <= kx_in;
      ky_ff   <= ky_in;
      kz_ff   <= kz_in;
      hash_ff <= hash_in;
   end

   assign push_valid = (state_ff == F_PUSH);
   assign push_data  = op_ff;
endmodule

@@ sv/vgc_back.sv @@
module vgc_back #(
   parameter int CAPACITY    = vgc_pkg::DEF_CAPACITY,
   parameter int PROBE_LIMIT = vgc_pkg::DEF_PROBE_LIMIT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  vgc_pkg::op_type pop_data,
   output logic            clearing,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [111:0]    rsp_data,
   output logic [2:0]      rsp_user,
   output logic            rsp_last
);
   import vgc_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int PW = $clog2(PROBE_LIMIT + 1);

   localparam logic [3:0] B_IDLE     = 4'd0;
   localparam logic [3:0] B_PROBE_RD = 4'd1;
   localparam logic [3:0] B_PROBE_CK = 4'd2;
   localparam logic [3:0] B_SCAN_RD  = 4'd3;
   localparam logic [3:0] B_SCAN_CK  = 4'd4;
   localparam logic [3:0] B_DIV      = 4'd5;
   localparam logic [3:0] B_MORE_RD  = 4'd6;
   localparam logic [3:0] B_MORE_CK  = 4'd7;
   localparam logic [3:0] B_OUT      = 4'd8;
   localparam logic [3:0] B_CLEAR    = 4'd9;

   logic [3:0]    state_ff, state_in;
   op_type        op_ff, op_in;
   logic [AW-1:0] probe_ff, probe_in, clr_ff, clr_in, ptr_ff, ptr_in, slot_ff, slot_in;
   logic [PW-1:0] pcnt_ff, pcnt_in;
   logic [AW:0]   scan_ff, scan_in;
   logic          clr_pend_ff, clr_pend_in;
   logic [31:0]   res_x_ff, res_y_ff, res_z_ff, res_x_in, res_y_in, res_z_in;
   logic [15:0]   res_i_ff, res_i_in;
   logic          res_pv_ff, res_pv_in, res_last_ff, res_last_in;
   logic [1:0]    res_st_ff, res_st_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [111:0]  rsp_data_ff, rsp_data_in;
   logic [2:0]    rsp_user_ff, rsp_user_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [3:0]    neg_ff, neg_in;

   logic          used_we, used_wd, used_rd, ent_we;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     ent_wd, ent_rd;

   logic          div_start;
   logic [47:0]   dv_x, dv_y, dv_z, dv_i, dn;
   logic [47:0]   q_x, q_y, q_z, q_i, r_x, r_y, r_z, r_i;
   logic          dn_x, dn_y, dn_z, dn_i;
   logic          key_hit;

   vgc_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_used (
      .clock, .wr_en(used_we), .wr_addr, .wr_data(used_wd), .rd_addr, .rd_data(used_rd));
   vgc_ram #(.WIDTH($bits(entry_type)), .DEPTH(CAPACITY)) u_entry (
      .clock, .wr_en(ent_we), .wr_addr, .wr_data(ent_wd), .rd_addr, .rd_data(ent_rd));

   assign dv_x = ent_rd.sum_x[47] ? (~ent_rd.sum_x + 48'd1) : ent_rd.sum_x;
   assign dv_y = ent_rd.sum_y[47] ? (~ent_rd.sum_y + 48'd1) : ent_rd.sum_y;
   assign dv_z = ent_rd.sum_z[47] ? (~ent_rd.sum_z + 48'd1) : ent_rd.sum_z;
   assign dv_i = {16'd0, ent_rd.sum_i};
   assign dn   = {32'd0, ent_rd.count};

   vgc_divider #(.WIDTH(48)) u_avg_x (
      .clock, .reset, .start(div_start), .dividend(dv_x), .divisor(dn),
      .done(dn_x), .quotient(q_x), .remainder(r_x));
   vgc_divider #(.WIDTH(48)) u_avg_y (
      .clock, .reset, .start(div_start), .dividend(dv_y), .divisor(dn),
      .done(dn_y), .quotient(q_y), .remainder(r_y));
   vgc_divider #(.WIDTH(48)) u_avg_z (
      .clock, .reset, .start(div_start), .dividend(dv_z), .divisor(dn),
      .done(dn_z), .quotient(q_z), .remainder(r_z));
   vgc_divider #(.WIDTH(48)) u_avg_i (
      .clock, .reset, .start(div_start), .dividend(dv_i), .divisor(dn),
      .done(dn_i), .quotient(q_i), .remainder(r_i));

   assign key_hit = (ent_rd.key_x == op_ff.key_x) && (ent_rd.key_y == op_ff.key_y) &&
                    (ent_rd.key_z == op_ff.key_z);
   assign pop_ready = (state_ff == B_IDLE);
   assign clearing  = (state_ff == B_CLEAR);
   assign div_start = (state_ff == B_SCAN_CK) && used_rd;

   always_comb begin
      rd_addr = probe_ff;
      if (state_ff == B_SCAN_RD || state_ff == B_MORE_RD) begin
         rd_addr = scan_ff[AW-1:0];
      end
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      probe_in    = probe_ff;
      pcnt_in     = pcnt_ff;
      clr_in      = clr_ff;
      ptr_in      = ptr_ff;
      slot_in     = slot_ff;
      scan_in     = scan_ff;
      clr_pend_in = clr_pend_ff;
      neg_in      = neg_ff;
      res_x_in    = res_x_ff;
      res_y_in    = res_y_ff;
      res_z_in    = res_z_ff;
      res_i_in    = res_i_ff;
      res_pv_in   = res_pv_ff;
      res_last_in = res_last_ff;
      res_st_in   = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      used_we = 1'b0;
      used_wd = 1'b0;
      ent_we  = 1'b0;
      wr_addr = probe_ff;
      ent_wd  = ent_rd;
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               op_in       = pop_data;
               res_x_in    = '0;
               res_y_in    = '0;
               res_z_in    = '0;
               res_i_in    = '0;
               res_pv_in   = 1'b0;
               res_last_in = 1'b0;
               res_st_in   = ST_OK;
               unique case (pop_data.op)
                  OP_PASS: begin
                     res_x_in  = pop_data.x;
                     res_y_in  = pop_data.y;
                     res_z_in  = pop_data.z;
                     res_i_in  = pop_data.inten;
                     res_pv_in = 1'b1;
                     state_in  = B_OUT;
                  end
                  OP_DRAIN: begin
                     scan_in  = {1'b0, ptr_ff};
                     state_in = B_SCAN_RD;
                  end
                  default: begin
                     probe_in = pop_data.slot[AW-1:0];
                     pcnt_in  = '0;
                     state_in = B_PROBE_RD;
                  end
               endcase
            end
         end
         B_PROBE_RD: state_in = B_PROBE_CK;
         B_PROBE_CK: begin
            if (!used_rd) begin
               // free slot: claim it
               used_we      = 1'b1;
               used_wd      = 1'b1;
               ent_we       = 1'b1;
               ent_wd.key_x = op_ff.key_x;
               ent_wd.key_y = op_ff.key_y;
               ent_wd.key_z = op_ff.key_z;
               ent_wd.sum_x = {{16{op_ff.x[31]}}, op_ff.x};
               ent_wd.sum_y = {{16{op_ff.y[31]}}, op_ff.y};
               ent_wd.sum_z = {{16{op_ff.z[31]}}, op_ff.z};
               ent_wd.sum_i = {16'd0, op_ff.inten};
               ent_wd.count = 16'd1;
               state_in     = B_OUT;
            end else if (key_hit) begin
               if (ent_rd.count == COUNT_MAX) begin
                  res_st_in = ST_SAT;
               end else begin
                  ent_we       = 1'b1;
                  ent_wd.sum_x = ent_rd.sum_x + {{16{op_ff.x[31]}}, op_ff.x};
                  ent_wd.sum_y = ent_rd.sum_y + {{16{op_ff.y[31]}}, op_ff.y};
                  ent_wd.sum_z = ent_rd.sum_z + {{16{op_ff.z[31]}}, op_ff.z};
                  ent_wd.sum_i = ent_rd.sum_i + {16'd0, op_ff.inten};
                  ent_wd.count = ent_rd.count + 16'd1;
               end
               state_in = B_OUT;
            end else if (pcnt_ff == PW'(PROBE_LIMIT - 1)) begin
               res_st_in = ST_FULL;
               state_in  = B_OUT;
            end else begin
               pcnt_in  = pcnt_ff + 1'b1;
               probe_in = (probe_ff == AW'(CAPACITY - 1)) ? '0 : probe_ff + 1'b1;
               state_in = B_PROBE_RD;
            end
         end
         B_SCAN_RD: begin
            if (scan_ff == (AW+1)'(CAPACITY)) begin
               ptr_in    = '0;
               res_st_in = ST_EMPTY;
               state_in  = B_OUT;
            end else begin
               state_in = B_SCAN_CK;
            end
         end
         B_SCAN_CK: begin
            if (used_rd) begin
               slot_in  = scan_ff[AW-1:0];
               neg_in   = {1'b0, ent_rd.sum_z[47], ent_rd.sum_y[47], ent_rd.sum_x[47]};
               state_in = B_DIV;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = B_SCAN_RD;
            end
         end
         B_DIV: begin
            if (dn_x && dn_y && dn_z && dn_i) begin
               res_x_in  = neg_ff[0] ? (~q_x[31:0] + 32'd1) : q_x[31:0];
               res_y_in  = neg_ff[1] ? (~q_y[31:0] + 32'd1) : q_y[31:0];
               res_z_in  = neg_ff[2] ? (~q_z[31:0] + 32'd1) : q_z[31:0];
               res_i_in  = q_i[15:0];
               res_pv_in = 1'b1;
               scan_in   = {1'b0, slot_ff} + 1'b1;
               state_in  = B_MORE_RD;
            end
         end
         B_MORE_RD: begin
            if (scan_ff == (AW+1)'(CAPACITY)) begin
               // final occupied slot: emit, then wipe the table
               res_last_in = 1'b1;
               clr_pend_in = 1'b1;
               ptr_in      = '0;
               state_in    = B_OUT;
            end else begin
               state_in = B_MORE_CK;
            end
         end
         B_MORE_CK: begin
            if (used_rd) begin
               ptr_in   = slot_ff + 1'b1;
               state_in = B_OUT;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = B_MORE_RD;
            end
         end
         B_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_i_ff, res_z_ff, res_y_ff, res_x_ff};
               rsp_user_in  = {res_st_ff, res_pv_ff};
               rsp_last_in  = res_last_ff;
               if (clr_pend_ff) begin
                  clr_in   = '0;
                  state_in = B_CLEAR;
               end else begin
                  state_in = B_IDLE;
               end
            end
         end
         B_CLEAR: begin
            used_we     = 1'b1;
            used_wd     = 1'b0;
            wr_addr     = clr_ff;
            clr_pend_in = 1'b0;
            ptr_in      = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == AW'(CAPACITY - 1)) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         ptr_ff       <= '0;
         clr_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ptr_ff       <= ptr_in;
         clr_pend_ff  <= clr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      probe_ff    <= probe_in;
      pcnt_ff     <= pcnt_in;
      slot_ff     <= slot_in;
      scan_ff     <= scan_in;
      neg_ff      <= neg_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_z_ff    <= res_z_in;
      res_i_ff    <= res_i_in;
      res_pv_ff   <= res_pv_in;
      res_last_ff <= res_last_in;
      res_st_ff   <= res_st_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_user  = rsp_user_ff;
   assign rsp_last  = rsp_last_ff;
endmodule

@@ sv/vgc_checker.sv @@
`include "voxel_grid_centroid_downsample_unit_defines.svh"
module vgc_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [111:0] rsp_tdata,
   input logic [2:0]   rsp_tuser,
   input logic         rsp_tlast
);
   import vgc_pkg::*;

   logic [115:0] rsp_word, rsp_word_ff;
   logic         rsp_stall, rsp_held, rsp_last_beat, rsp_point, status_ok;

   assign rsp_word      = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign rsp_stall     = rsp_tvalid && !rsp_tready;
   assign rsp_held      = rsp_tvalid && (rsp_word == rsp_word_ff);
   assign rsp_last_beat = rsp_tvalid && rsp_tlast;
   assign rsp_point     = rsp_tvalid && rsp_tuser[0];
   assign status_ok     = (rsp_tuser[2:1] == ST_OK);

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word;
   end

   `VGC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_held, "stalled result changed")
   `VGC_ASSERT_SAME(a_last_point, clock, reset, rsp_last_beat, rsp_tuser[0] && status_ok, "bad last")
   `VGC_ASSERT_SAME(a_point_ok, clock, reset, rsp_point, status_ok, "point with error status")
endmodule

bind voxel_grid_centroid_downsample_unit vgc_checker u_vgc_checker (.*);

@@ dv/vgc_checker.sv @@
`timescale 1ns / 100ps

module vgc_scoreboard
   import vgc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [111:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [111:0] rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [31:0]  csr_data,
   output int           error_count,
   output int           pending_count
);

   localparam int CAP   = DEF_CAPACITY;
   localparam int PROBE = DEF_PROBE_LIMIT;

   typedef struct packed {
      logic [111:0] data;
      logic [2:0]   user;
      logic         tlast;
   } voxel_rsp_t;

   logic [31:0]        cell_edge;
   logic signed [63:0] cell_x [CAP];
   logic signed [63:0] cell_y [CAP];
   logic signed [63:0] cell_z [CAP];
   logic signed [63:0] acc_x [CAP];
   logic signed [63:0] acc_y [CAP];
   logic signed [63:0] acc_z [CAP];
   logic [31:0]        acc_i [CAP];
   logic [31:0]        hits [CAP];
   bit                 occupied [CAP];
   int                 scan_ptr;
   voxel_rsp_t         centroid_q [$];

   function automatic logic signed [63:0] cell_index(logic signed [31:0] c);
      logic [63:0] mag;
      if (c < 0) begin
         mag = -64'(c);
         return -$signed(mag / cell_edge) - 1;
      end
      return $signed(64'(c) / cell_edge);
   endfunction

   function automatic void wipe_grid();
      for (int i = 0; i < CAP; i++) occupied[i] = 0;
      scan_ptr = 0;
   endfunction

   function automatic voxel_rsp_t predict_voxel(logic kind, logic [111:0] d);
      voxel_rsp_t r;
      logic signed [31:0] px, py, pz;
      logic [15:0] pi;
      logic signed [63:0] kx, ky, kz, n;
      logic [31:0] h;
      int s, i, j;
      bit more;
      r = '0;
      px = d[31:0]; py = d[63:32]; pz = d[95:64]; pi = d[111:96];
      if (kind == KIND_ADD) begin
         if (cell_edge < MIN_VOXEL) begin
            r.data = d;
            r.user = {ST_OK, 1'b1};
            return r;
         end
         kx = cell_index(px); ky = cell_index(py); kz = cell_index(pz);
         h = (kx[31:0] * HASH_X) ^ (ky[31:0] * HASH_Y) ^ (kz[31:0] * HASH_Z);
         r.user = {ST_FULL, 1'b0};
         for (int p = 0; p < PROBE; p++) begin
            s = (h % CAP + p) % CAP;
            if (!occupied[s]) begin
               occupied[s] = 1;
               cell_x[s] = kx; cell_y[s] = ky; cell_z[s] = kz;
               acc_x[s] = px; acc_y[s] = py; acc_z[s] = pz;
               acc_i[s] = pi; hits[s] = 1;
               r.user = {ST_OK, 1'b0};
               break;
            end
            if (cell_x[s] == kx && cell_y[s] == ky && cell_z[s] == kz) begin
               if (hits[s] >= COUNT_MAX) r.user = {ST_SAT, 1'b0};
               else begin
                  acc_x[s] += px; acc_y[s] += py; acc_z[s] += pz;
                  acc_i[s] += pi; hits[s]++;
                  r.user = {ST_OK, 1'b0};
               end
               break;
            end
         end
         return r;
      end
      for (i = scan_ptr; i < CAP; i++) if (occupied[i]) break;
      if (i >= CAP) begin
         scan_ptr = 0;
         r.user = {ST_EMPTY, 1'b0};
         return r;
      end
      n = (hits[i] != 0) ? hits[i] : 1;
      r.data[31:0]   = 32'(acc_x[i] / n);
      r.data[63:32]  = 32'(acc_y[i] / n);
      r.data[95:64]  = 32'(acc_z[i] / n);
      r.data[111:96] = 16'(acc_i[i] / 32'(n));
      r.user = {ST_OK, 1'b1};
      more = 0;
      for (j = i + 1; j < CAP; j++) if (occupied[j]) begin more = 1; break; end
      if (more) scan_ptr = i + 1;
      else begin
         r.tlast = 1;
         wipe_grid();
      end
      return r;
   endfunction

   always @(posedge clock) begin
      voxel_rsp_t want, got;
      if (reset) begin
         cell_edge = VOXEL_RESET;
         wipe_grid();
         centroid_q.delete();
         error_count <= 0;
      end else begin
         if (csr_valid && csr_ready) cell_edge = csr_data;
         if (req_tvalid && req_tready)
            centroid_q.insert(centroid_q.size(), predict_voxel(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tuser, rsp_tlast};
            if (centroid_q.size() == 0) begin
               if (error_count < 10) $display("unexpected response %h", got);
               error_count <= error_count + 1;
            end else begin
               want = centroid_q.pop_front();
               if (want != got) begin
                  if (error_count < 10)
                     $display("mismatch: exp data %h user %b last %b, got data %h user %b last %b",
                              want.data, want.user, want.tlast, got.data, got.user, got.tlast);
                  error_count <= error_count + 1;
               end
            end
         end
      end
      pending_count = centroid_q.size();
   end

endmodule

@@ dv/tb_voxel_grid_centroid_downsample_unit.sv @@
`timescale 1ns / 100ps

module tb_voxel_grid_centroid_downsample_unit;
   import vgc_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;   // x, y, z, intensity
   logic         req_tuser = 0;    // kind
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [111:0] rsp_tdata;        // x, y, z, intensity
   logic [2:0]   rsp_tuser;        // point_valid, status
   logic         rsp_tlast;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [31:0]  csr_data = '0;
   int           error_count, pending_count;
   int           idle_cycles = 0;
   logic [31:0]  cell_span;
   logic [31:0]  grid_base [3];

   always #4 clock = ~clock;

   voxel_grid_centroid_downsample_unit i_dut (.*);

   vgc_scoreboard i_checker (.*);

   // watchdog: cycles with no transaction on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 40000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver with random backpressure; some responses meet no stall at all
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   // each item may first drop valid for a random idle gap; with no gap, valid stays up between items
   task automatic send_item(logic kind, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [15:0] inten);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {inten, z, y, x};
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
   endtask

   // let every outstanding transaction drain, then allow for the clearing pass
   task automatic wait_quiet();
      req_tvalid <= 0;
      do @(negedge clock); while (pending_count != 0);
      repeat (3000) @(posedge clock);
   endtask

   task automatic write_voxel(logic [31:0] vs);
      wait_quiet();
      csr_valid <= 1;
      csr_data  <= vs;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      csr_valid <= 0;
      cell_span = vs;
   endtask

   // point near a small cluster so cells get reused
   task automatic send_cluster_point();
      logic [31:0] c [3];
      for (int a = 0; a < 3; a++)
         c[a] = grid_base[a] + $urandom_range(0, 3) * cell_span + $urandom_range(0, 65535);
      send_item(KIND_ADD, c[0], c[1], c[2], 16'($urandom));
   endtask

   task automatic drain_all();
      repeat (40) begin
         send_item(KIND_DRAIN, $urandom, $urandom, $urandom, 16'($urandom));
      end
   endtask

   initial begin
      logic [31:0] sizes [6];
      sizes = '{32'd655, 32'd65536, 32'h0004_0000, 32'hFFFF_FFFF, 32'd100, 32'h0000_8000};
      cell_span = VOXEL_RESET;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty drain, extremes, exact negative multiple, reuse
      send_item(KIND_DRAIN, 0, 0, 0, 0);
      send_item(KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 0, 16'hFFFF);
      send_item(KIND_ADD, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0001_0000, 0);
      send_item(KIND_ADD, 32'h0000_8000, 32'h0000_4000, 32'h0000_1000, 16'h1234);
      send_item(KIND_ADD, 32'h0000_C000, 32'h0000_2000, 32'h0000_3000, 16'hFFFF);
      send_item(KIND_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000);
      drain_all();
      // table full: y cells 1024 apart share one home slot, so probes run out
      for (int i = 0; i < 20; i++)
         send_item(KIND_ADD, 0, 32'(i) << 26, 0, 16'(i));
      write_voxel(32'd654);   // pass-through
      send_item(KIND_ADD, 32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF, 16'hA5A5);
      send_item(KIND_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 0, 16'hFFFF);
      drain_all();
      write_voxel(32'd0);
      send_item(KIND_ADD, 32'hFFFF_FFFF, 0, 32'h0F0F_0F0F, 0);

      // random phases across voxel sizes
      for (int ph = 0; ph < 8; ph++) begin
         write_voxel((ph % 4 == 3) ? $urandom : sizes[ph % 6]);
         for (int a = 0; a < 3; a++) grid_base[a] = $urandom;
         for (int i = 0; i < 110; i++) begin
            case ($urandom_range(0, 9))
               0: send_item(KIND_ADD, $urandom, $urandom, $urandom, 16'($urandom));
               1: send_item(KIND_DRAIN, $urandom, $urandom, $urandom, 16'($urandom));
               default: send_cluster_point();
            endcase
         end
         if (ph == 5) wait_quiet();   // sender holds until all responses are back
         drain_all();
      end

      // flood many distinct cells to load the table
      write_voxel(32'd65536);
      for (int i = 0; i < 250; i++)
         send_item(KIND_ADD, $urandom, $urandom, $urandom, 16'($urandom));
      for (int i = 0; i < 250; i++) send_item(KIND_DRAIN, 0, 0, 0, 0);
      write_voxel(32'hFFFF_FFFF);

      wait_quiet();
      if (error_count == 0 && pending_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/vgc_pkg.sv
sv/vgc_ram.sv
sv/vgc_divider.sv
sv/vgc_queue.sv
sv/vgc_front.sv
sv/vgc_back.sv
sv/voxel_grid_centroid_downsample_unit.sv
sv/vgc_checker.sv
dv/vgc_checker.sv
dv/tb_voxel_grid_centroid_downsample_unit.sv
